// File: design/tbrl_pkg.sv
package tbrl_pkg;

  // Default widths of the time and counter state
  localparam int DEF_TIME_WIDTH  = 32;
  localparam int DEF_COUNT_WIDTH = 32;

  // Fixed field widths
  localparam int LEVEL_W   = 26;   // bucket level, milli-tokens
  localparam int CFG_W     = 16;   // widest config register
  localparam int CFG_IDX_W = 2;
  localparam int NOW_W     = 32;
  localparam int CNT_OUT_W = 32;
  localparam int RATE_W    = 40;   // measured rate, Q8
  localparam int RATE_FRAC = 8;

  localparam int MILLI = 1000;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LIMIT_ENABLE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REFILL_RATE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BURST_LIMIT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 2'd3;

  // Register reset values
  localparam logic             RST_LIMIT_ENABLE  = 1'b1;
  localparam logic [CFG_W-1:0] RST_REFILL_RATE   = 16'd10;
  localparam logic [CFG_W-1:0] RST_BURST_LIMIT   = 16'd20;
  localparam logic [CFG_W-1:0] RST_WINDOW_LENGTH = 16'd60;
  localparam logic [LEVEL_W-1:0] RST_LEVEL = LEVEL_W'(20 * MILLI);
  localparam logic [LEVEL_W-1:0] MAX_LEVEL = LEVEL_W'(65535 * MILLI);

  // Stream payload widths, padded to whole bytes
  localparam int IN_TDATA_W  = 40;   // now_ms, exempt
  localparam int OUT_TDATA_W = 136;  // allowed .. measured_rate

endpackage

// File: design/token_bucket_rate_limiter.sv
// Token bucket rate limiter. Each request on the slave stream carries a
// millisecond timestamp and an exempt flag; one result per request leaves on
// the master stream with the allow decision, the bucket level in
// milli-tokens, the wrapping total and rejected counters and the last
// measured rate (allowed requests per second, Q8). Requests are handled one
// at a time by a small sequencer around one registered multiplier, a
// divide-by-1000 stage that retires one byte of whole seconds per cycle by
// reciprocal multiplication, and one restoring divider for the rate that
// retires one quotient bit per cycle. A bypassed request (limiting off or
// exempt) goes from idle straight to the emit step; a rejected request
// passes the multiply, refill and consume steps first; an allowed request
// adds SD = ceil(TIME_WIDTH / 8) byte steps for the seconds and the window
// check; an allowed request that closes the statistics window with nonzero
// elapsed seconds adds DW = COUNT_WIDTH + 8 rate divider steps. The emit step
// registers the result as the sequencer returns to idle, and it stalls while
// the previous result still waits. The result sits in an output register, so
// the next request is taken once the sequencer is back in idle even if the
// last result has not been consumed yet. Config writes are taken every cycle
// and must only happen while no request is in flight.
module token_bucket_rate_limiter #(
  parameter int TIME_WIDTH  = tbrl_pkg::DEF_TIME_WIDTH,
  parameter int COUNT_WIDTH = tbrl_pkg::DEF_COUNT_WIDTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // request stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [31:0] now_ms, [32] exempt, rest zero
  input  logic [tbrl_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [0] allowed, [26:1] tokens_left, [58:27] total_count,
  // [90:59] rejected_count, [130:91] measured_rate, rest zero
  output logic [tbrl_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // config write channel
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [tbrl_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [tbrl_pkg::CFG_W-1:0]         cfg_data_i
);
  import tbrl_pkg::*;

  // rate divider widths: dividend holds count << 8, divisor whole seconds
  localparam int DW    = COUNT_WIDTH + RATE_FRAC;
  localparam int SW    = TIME_WIDTH;
  localparam int CNT_W = $clog2(DW);
  localparam int PROD_W = LEVEL_W + CFG_W;

  // seconds stage: long division by 1000, one byte per step
  localparam int SEC_DIG = (TIME_WIDTH + 7) / 8;
  localparam int SEC_PW  = SEC_DIG * 8;
  localparam int SEC_RW  = 10;               // remainder, below 1000
  localparam int SEC_TW  = SEC_RW + 8;       // partial dividend, below 256000
  localparam int SEC_SH  = 28;
  localparam int SEC_MW  = SEC_TW + 19;
  // ceil(2^28 / 1000); exact floor for any partial dividend below 2^18
  localparam logic [18:0] SEC_RECIP = 19'd268436;

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_MUL     = 8'b0000_0010,
    ST_REFILL  = 8'b0000_0100,
    ST_CONSUME = 8'b0000_1000,
    ST_SECS    = 8'b0001_0000,
    ST_CHECK   = 8'b0010_0000,
    ST_RATE    = 8'b0100_0000,
    ST_EMIT    = 8'b1000_0000
  } state_e;

  state_e state_q;

  // config registers
  logic             enable_q;
  logic [CFG_W-1:0] refill_q, burst_q, window_q;

  // limiter state
  logic [LEVEL_W-1:0]     level_q;
  logic [TIME_WIDTH-1:0]  last_refill_q, win_start_q;
  logic [COUNT_WIDTH-1:0] win_allowed_q, total_q, rejected_q;
  logic [RATE_W-1:0]      rate_q;

  // per-request working registers
  logic [TIME_WIDTH-1:0] now_q;
  logic                  allowed_q;
  logic                  el_nz_q;    // elapsed time nonzero
  logic                  el_big_q;   // elapsed alone overflows the bucket
  logic [PROD_W-1:0]     prod_q;
  logic [LEVEL_W-1:0]    cap_q;

  // seconds stage: dividend bytes shift out, quotient bytes shift in
  logic [SEC_PW-1:0] sec_num_q;
  logic [SEC_RW-1:0] sec_rem_q;

  // rate divider
  logic [DW-1:0]    div_num_q;   // dividend shifts out, quotient shifts in
  logic [SW-1:0]    div_rem_q;
  logic [SW-1:0]    div_den_q;
  logic [CNT_W-1:0] div_cnt_q;

  // output register
  logic                   m_valid_q;
  logic [OUT_TDATA_W-1:0] m_data_q;

  // combinational helpers
  logic [TIME_WIDTH-1:0] now_in, elapsed, win_diff, secs;
  logic                  in_exempt, s_fire;
  logic [SW:0]           rem_sh, rem_sub;
  logic                  div_fits;
  logic [PROD_W:0]       fill_sum;
  logic                  fill_full;
  logic [SEC_TW-1:0]     sec_t;
  logic [7:0]            sec_dig;
  logic [SEC_RW-1:0]     sec_r;

  assign now_in    = TIME_WIDTH'(s_axis_tdata[NOW_W-1:0]);
  assign in_exempt = s_axis_tdata[NOW_W];
  assign s_fire    = s_axis_tvalid && s_axis_tready;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  assign elapsed  = now_q - last_refill_q;
  assign win_diff = now_q - win_start_q;
  assign secs     = TIME_WIDTH'(sec_num_q);

  // one byte of ms / 1000 per step
  assign sec_t   = {sec_rem_q, sec_num_q[SEC_PW-1 -: 8]};
  assign sec_dig = 8'((SEC_MW'(sec_t) * SEC_MW'(SEC_RECIP)) >> SEC_SH);
  assign sec_r   = SEC_RW'(sec_t - SEC_TW'(sec_dig) * SEC_TW'(MILLI));

  // one restoring step per cycle
  assign rem_sh   = {div_rem_q, div_num_q[DW-1]};
  assign rem_sub  = rem_sh - {1'b0, div_den_q};
  assign div_fits = rem_sh >= {1'b0, div_den_q};

  // refill saturates when level plus added tokens reaches capacity
  assign fill_sum  = {1'b0, prod_q} + (PROD_W + 1)'(level_q);
  assign fill_full = el_big_q || (fill_sum >= (PROD_W + 1)'(cap_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      enable_q      <= RST_LIMIT_ENABLE;
      refill_q      <= RST_REFILL_RATE;
      burst_q       <= RST_BURST_LIMIT;
      window_q      <= RST_WINDOW_LENGTH;
      level_q       <= RST_LEVEL;
      last_refill_q <= '0;
      win_start_q   <= '0;
      win_allowed_q <= '0;
      total_q       <= '0;
      rejected_q    <= '0;
      rate_q        <= '0;
      now_q         <= '0;
      allowed_q     <= 1'b0;
      el_nz_q       <= 1'b0;
      el_big_q      <= 1'b0;
      prod_q        <= '0;
      cap_q         <= '0;
      sec_num_q     <= '0;
      sec_rem_q     <= '0;
      div_num_q     <= '0;
      div_rem_q     <= '0;
      div_den_q     <= '0;
      div_cnt_q     <= '0;
      m_valid_q     <= 1'b0;
      m_data_q      <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_LIMIT_ENABLE:  enable_q <= cfg_data_i[0];
          CFG_REFILL_RATE:   refill_q <= cfg_data_i;
          CFG_BURST_LIMIT:   burst_q  <= cfg_data_i;
          CFG_WINDOW_LENGTH: window_q <= cfg_data_i;
          default: ;
        endcase
      end

      // emit step reloads the register itself when it fires
      if (m_valid_q && m_axis_tready && (state_q != ST_EMIT)) begin
        m_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (s_fire) begin
            now_q     <= now_in;
            allowed_q <= 1'b1;
            state_q   <= (enable_q && !in_exempt) ? ST_MUL : ST_EMIT;
          end
        end
        ST_MUL: begin
          prod_q   <= PROD_W'(LEVEL_W'(elapsed)) * PROD_W'(refill_q);
          el_nz_q  <= (elapsed != '0);
          el_big_q <= ((elapsed >> LEVEL_W) != '0) && (refill_q != '0);
          cap_q    <= LEVEL_W'(LEVEL_W'(burst_q) * LEVEL_W'(MILLI));
          state_q  <= ST_REFILL;
        end
        ST_REFILL: begin
          if (el_nz_q) begin
            level_q       <= fill_full ? cap_q : level_q + LEVEL_W'(prod_q);
            last_refill_q <= now_q;
          end
          total_q <= total_q + 1'b1;
          state_q <= ST_CONSUME;
        end
        ST_CONSUME: begin
          if (level_q >= LEVEL_W'(MILLI)) begin
            level_q       <= level_q - LEVEL_W'(MILLI);
            win_allowed_q <= win_allowed_q + 1'b1;
            // elapsed window time in ms / 1000 -> whole seconds
            sec_num_q     <= SEC_PW'(win_diff);
            sec_rem_q     <= '0;
            div_cnt_q     <= CNT_W'(SEC_DIG - 1);
            state_q       <= ST_SECS;
          end else begin
            allowed_q  <= 1'b0;
            rejected_q <= rejected_q + 1'b1;
            state_q    <= ST_EMIT;
          end
        end
        ST_SECS: begin
          sec_num_q <= {sec_num_q[SEC_PW-9:0], sec_dig};
          sec_rem_q <= sec_r;
          div_cnt_q <= div_cnt_q - 1'b1;
          if (div_cnt_q == '0) begin
            state_q <= ST_CHECK;
          end
        end
        ST_RATE: begin
          div_num_q <= {div_num_q[DW-2:0], div_fits};
          div_rem_q <= div_fits ? rem_sub[SW-1:0] : rem_sh[SW-1:0];
          div_cnt_q <= div_cnt_q - 1'b1;
          if (div_cnt_q == '0) begin
            rate_q        <= RATE_W'({div_num_q[DW-2:0], div_fits});
            win_start_q   <= now_q;
            win_allowed_q <= '0;
            state_q       <= ST_EMIT;
          end
        end
        ST_CHECK: begin
          if (secs >= TIME_WIDTH'(window_q)) begin
            if (secs == '0) begin
              // zero divisor: rate reads zero
              rate_q        <= '0;
              win_start_q   <= now_q;
              win_allowed_q <= '0;
              state_q       <= ST_EMIT;
            end else begin
              // Q8 rate = floor((allowed << 8) / secs)
              div_num_q <= DW'({win_allowed_q, {RATE_FRAC{1'b0}}});
              div_den_q <= secs;
              div_rem_q <= '0;
              div_cnt_q <= CNT_W'(DW - 1);
              state_q   <= ST_RATE;
            end
          end else begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_data_q  <= OUT_TDATA_W'({rate_q,
                                       CNT_OUT_W'(rejected_q),
                                       CNT_OUT_W'(total_q),
                                       level_q,
                                       allowed_q});
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_level_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    level_q <= MAX_LEVEL)
    else $error("bucket level above largest capacity");

  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == ST_EMIT))
    else $error("result raised outside emit step");

  a_reject_counts_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rejected_q != $past(rejected_q)) |-> (total_q != $past(total_q, 2)))
    else $error("rejected request not counted in total");

  a_rate_opens_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rate_q != $past(rate_q)) |-> (win_allowed_q == '0))
    else $error("rate update did not open a new window");
`endif

endmodule

// File: dv/token_bucket_rate_limiter_tb.sv
// Testbench for the token bucket rate limiter.
// Requests stream in with a millisecond timestamp and an exempt flag; the
// block returns one decision per request. A behavioral copy of the bucket,
// counters and window-rate logic runs alongside. Each accepted request queues
// its predicted decision, and every result that leaves the block is checked
// field by field against the oldest one.
// A short directed table comes first. Its early rows carry hand-worked
// decisions for reset, time wrap, an over-capacity bucket, zero rate, zero
// burst, zero window and register masking. Seven random phases follow, each
// opened with a register setup while the block is idle.
module token_bucket_rate_limiter_tb;
  import tbrl_pkg::*;

  // Decision as it sits in m_axis_tdata, allowed in bit 0
  typedef struct packed {
    logic [RATE_W-1:0]    rate;
    logic [CNT_OUT_W-1:0] rejected;
    logic [CNT_OUT_W-1:0] total;
    logic [LEVEL_W-1:0]   tokens;
    logic                 allowed;
  } decision_t;

  localparam int DEC_W = $bits(decision_t);

  typedef enum logic [1:0] {ROW_WRITE, ROW_REQUEST, ROW_TYPED} row_kind_e;

  typedef struct {
    row_kind_e            kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     reg_val;
    logic [NOW_W-1:0]     now;
    logic                 exempt;
    decision_t            want;
  } plan_row_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i   = '0;
  logic [CFG_W-1:0]       cfg_data_i    = '0;

  // Register shadows
  logic                   cur_enable = RST_LIMIT_ENABLE;
  logic [CFG_W-1:0]       cur_rate   = RST_REFILL_RATE;
  logic [CFG_W-1:0]       cur_burst  = RST_BURST_LIMIT;
  logic [CFG_W-1:0]       cur_window = RST_WINDOW_LENGTH;

  // Bucket and statistics shadows
  logic [LEVEL_W-1:0]     level_mt       = RST_LEVEL;
  logic [NOW_W-1:0]       refill_stamp   = '0;
  logic [NOW_W-1:0]       window_open_ms = '0;
  logic [31:0]            window_grants  = '0;
  logic [CNT_OUT_W-1:0]   limited_total  = '0;
  logic [CNT_OUT_W-1:0]   rejected_total = '0;
  logic [RATE_W-1:0]      rate_q8        = '0;

  decision_t pending_decisions[$];
  plan_row_t plan[$];
  int        mismatches   = 0;
  int        results_seen = 0;
  int        hold_left    = 0;
  bit        calm         = 1'b0;   // no random idling on either side while set

  token_bucket_rate_limiter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Advances the bucket for one request and returns what the block should say.
  // Bypassed requests touch nothing and just report the current state.
  function automatic decision_t decide_request(input logic [NOW_W-1:0] now,
                                               input logic exempt);
    logic [NOW_W-1:0] elapsed;
    logic [NOW_W-1:0] span;
    logic [63:0]      cap;
    logic [63:0]      room;
    logic [63:0]      add;
    logic [63:0]      secs;
    logic [63:0]      grants;
    decision_t        d;
    d.allowed = 1'b1;
    if (cur_enable && !exempt) begin
      elapsed = now - refill_stamp;   // wraps, so going back reads as a long gap
      if (elapsed != 0) begin
        cap  = 64'(cur_burst) * 64'(MILLI);
        room = (64'(level_mt) >= cap) ? 64'd0 : cap - 64'(level_mt);
        // saturate instead of forming a huge product
        if (cur_rate != 0 && 64'(elapsed) > room / 64'(cur_rate))
          add = room + 64'd1;
        else
          add = 64'(elapsed) * 64'(cur_rate);
        // a bucket left above a lowered capacity gets clamped here
        level_mt     = (add >= room) ? LEVEL_W'(cap) : level_mt + LEVEL_W'(add);
        refill_stamp = now;
      end
      limited_total++;
      if (level_mt >= LEVEL_W'(MILLI)) begin
        level_mt -= LEVEL_W'(MILLI);
        window_grants++;
        span = now - window_open_ms;
        secs = 64'(span) / 64'(MILLI);
        if (secs >= 64'(cur_window)) begin
          grants = 64'(window_grants);
          // Q8 quotient, zero elapsed seconds gives zero
          if (secs == 0)
            rate_q8 = '0;
          else
            rate_q8 = RATE_W'(((grants / secs) << RATE_FRAC) |
                              (((grants % secs) << RATE_FRAC) / secs));
          window_open_ms = now;
          window_grants  = '0;
        end
      end else begin
        d.allowed = 1'b0;
        rejected_total++;
      end
    end
    d.tokens   = level_mt;
    d.total    = limited_total;
    d.rejected = rejected_total;
    d.rate     = rate_q8;
    return d;
  endfunction

  function automatic plan_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_W-1:0] val);
    plan_row_t r;
    r.kind    = ROW_WRITE;
    r.reg_idx = idx;
    r.reg_val = val;
    r.now     = '0;
    r.exempt  = 1'b0;
    r.want    = '0;
    return r;
  endfunction

  function automatic plan_row_t req_row(input logic [NOW_W-1:0] now,
                                        input logic exempt);
    plan_row_t r;
    r        = reg_row(CFG_LIMIT_ENABLE, '0);
    r.kind   = ROW_REQUEST;
    r.now    = now;
    r.exempt = exempt;
    return r;
  endfunction

  function automatic plan_row_t typed_row(input logic [NOW_W-1:0] now,
                                          input logic exempt,
                                          input logic ok,
                                          input logic [LEVEL_W-1:0] tokens,
                                          input logic [CNT_OUT_W-1:0] total,
                                          input logic [CNT_OUT_W-1:0] rejected,
                                          input logic [RATE_W-1:0] rate);
    plan_row_t r;
    r                = req_row(now, exempt);
    r.kind           = ROW_TYPED;
    r.want.allowed   = ok;
    r.want.tokens    = tokens;
    r.want.total     = total;
    r.want.rejected  = rejected;
    r.want.rate      = rate;
    return r;
  endfunction

  // Leaves cfg_valid_i high; the caller drops it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_LIMIT_ENABLE:  cur_enable = value[0];
      CFG_REFILL_RATE:   cur_rate   = value;
      CFG_BURST_LIMIT:   cur_burst  = value;
      CFG_WINDOW_LENGTH: cur_window = value;
      default: ;
    endcase
  endtask

  // Offers one request, with an occasional idle gap first. Typed rows queue
  // the hand-worked decision; the shadow state still advances.
  task automatic send_request(input logic [NOW_W-1:0] now, input logic exempt,
                              input bit typed, input decision_t typed_want);
    decision_t want;
    if (!calm && $urandom_range(0, 99) < 10) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'({exempt, now});
    do @(posedge clk_i); while (!s_axis_tready);
    want = decide_request(now, exempt);
    pending_decisions.push_back(typed ? typed_want : want);
  endtask

  task automatic drain_results();
    while (pending_decisions.size() != 0) @(posedge clk_i);
  endtask

  // Result side: check every accepted decision and drive tready. Twice in the
  // run the receiver holds off long enough for the block to back up and
  // drop s_axis_tready while requests keep coming.
  always @(posedge clk_i) begin : result_monitor
    decision_t got;
    decision_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = decision_t'(m_axis_tdata[DEC_W-1:0]);
      results_seen++;
      if (pending_decisions.size() == 0) begin
        report_mismatch($sformatf("result %0d with no request outstanding",
                                  results_seen));
      end else begin
        want = pending_decisions.pop_front();
        if (got.allowed !== want.allowed)
          report_mismatch($sformatf("result %0d allowed %0d, want %0d",
                                    results_seen, got.allowed, want.allowed));
        if (got.tokens !== want.tokens)
          report_mismatch($sformatf("result %0d tokens_left %0d, want %0d",
                                    results_seen, got.tokens, want.tokens));
        if (got.total !== want.total)
          report_mismatch($sformatf("result %0d total_count %0d, want %0d",
                                    results_seen, got.total, want.total));
        if (got.rejected !== want.rejected)
          report_mismatch($sformatf("result %0d rejected_count %0d, want %0d",
                                    results_seen, got.rejected, want.rejected));
        if (got.rate !== want.rate)
          report_mismatch($sformatf("result %0d measured_rate %0d, want %0d",
                                    results_seen, got.rate, want.rate));
        if (m_axis_tdata[OUT_TDATA_W-1:DEC_W] !== '0)
          report_mismatch($sformatf("result %0d padding bits %b", results_seen,
                                    m_axis_tdata[OUT_TDATA_W-1:DEC_W]));
      end
      if (results_seen % 500 == 250) hold_left = 200;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= calm || ($urandom_range(0, 99) >= 10);
    end
  end

  initial begin
    logic [NOW_W-1:0] stamp;
    logic [CFG_W-1:0] en_w;
    logic [CFG_W-1:0] rate_w;
    logic [CFG_W-1:0] burst_w;
    logic [CFG_W-1:0] win_w;
    int               pick;
    bit               in_cfg;

    // Directed table. Defaults after reset: enabled, 10 tok/s, burst 20,
    // window 60 s, bucket full at 20000 milli-tokens.
    plan.push_back(typed_row(32'd0,          1'b0, 1'b1, 26'd19000, 32'd1, 32'd0, 40'd0));
    plan.push_back(typed_row(32'd0,          1'b1, 1'b1, 26'd19000, 32'd1, 32'd0, 40'd0));
    plan.push_back(typed_row(32'd100,        1'b0, 1'b1, 26'd19000, 32'd2, 32'd0, 40'd0));
    // all-ones stamp: huge gap refills to cap and closes the window
    plan.push_back(typed_row(32'hFFFF_FFFF,  1'b0, 1'b1, 26'd19000, 32'd3, 32'd0, 40'd0));
    // wrap back to zero is a 1 ms gap
    plan.push_back(typed_row(32'd0,          1'b0, 1'b1, 26'd18010, 32'd4, 32'd0, 40'd0));
    plan.push_back(reg_row(CFG_REFILL_RATE,   16'd0));
    plan.push_back(reg_row(CFG_BURST_LIMIT,   16'd1));
    plan.push_back(reg_row(CFG_WINDOW_LENGTH, 16'd1));
    // capacity lowered, no gap: level stays above it
    plan.push_back(typed_row(32'd0,          1'b0, 1'b1, 26'd17010, 32'd5, 32'd0, 40'd0));
    // refill with zero rate still clamps to the new capacity
    plan.push_back(typed_row(32'd5,          1'b0, 1'b1, 26'd0,     32'd6, 32'd0, 40'd0));
    plan.push_back(typed_row(32'd6,          1'b0, 1'b0, 26'd0,     32'd7, 32'd1, 40'd0));
    plan.push_back(reg_row(CFG_REFILL_RATE,   16'hFFFF));
    plan.push_back(reg_row(CFG_BURST_LIMIT,   16'hFFFF));
    // saturating refill to the top level; 4 grants over 2 s -> 2.0 in Q8
    plan.push_back(typed_row(32'd2000,       1'b0, 1'b1, 26'd65534000, 32'd8, 32'd1, 40'd512));
    plan.push_back(reg_row(CFG_WINDOW_LENGTH, 16'd0));
    plan.push_back(reg_row(CFG_BURST_LIMIT,   16'd0));
    // zero window and zero elapsed seconds: rate reads zero
    plan.push_back(typed_row(32'd2000,       1'b0, 1'b1, 26'd65533000, 32'd9, 32'd1, 40'd0));
    // zero burst rejects everything limited
    plan.push_back(typed_row(32'd2001,       1'b0, 1'b0, 26'd0,    32'd10, 32'd2, 40'd0));
    // only bit 0 of the enable lands
    plan.push_back(reg_row(CFG_LIMIT_ENABLE,  16'hFFFE));
    plan.push_back(typed_row(32'd12345,      1'b0, 1'b1, 26'd0,    32'd10, 32'd2, 40'd0));
    plan.push_back(reg_row(CFG_LIMIT_ENABLE,  16'd1));
    plan.push_back(reg_row(CFG_REFILL_RATE,   16'd10));
    plan.push_back(reg_row(CFG_BURST_LIMIT,   16'd20));
    plan.push_back(reg_row(CFG_WINDOW_LENGTH, 16'd60));
    plan.push_back(req_row(32'h8000_0000, 1'b1));
    plan.push_back(req_row(32'h8000_0000, 1'b0));
    plan.push_back(req_row(32'h8000_01F4, 1'b0));
    plan.push_back(req_row(32'h7FFF_FFFF, 1'b0));
    plan.push_back(req_row(32'h5555_5555, 1'b0));
    plan.push_back(req_row(32'hAAAA_AAAA, 1'b1));
    plan.push_back(req_row(32'hAAAA_AAAA, 1'b0));

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    in_cfg = 1'b0;
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_WRITE) begin
        // registers change only with nothing in flight
        if (!in_cfg) begin
          s_axis_tvalid <= 1'b0;
          drain_results();
        end
        write_reg(plan[i].reg_idx, plan[i].reg_val);
        in_cfg = 1'b1;
      end else begin
        if (in_cfg) begin
          cfg_valid_i <= 1'b0;
          in_cfg = 1'b0;
        end
        send_request(plan[i].now, plan[i].exempt, plan[i].kind == ROW_TYPED,
                     plan[i].want);
      end
    end

    // Random phases: mostly rising timestamps with short gaps so refill,
    // rejection and window closing all happen, plus long jumps, random
    // stamps and steps backwards.
    for (int p = 0; p < 7; p++) begin
      s_axis_tvalid <= 1'b0;
      drain_results();
      case (p)
        0: begin
          en_w = {15'($urandom), 1'b1}; rate_w = '0; burst_w = 16'd1; win_w = 16'd1;
        end
        1: begin
          en_w = 16'd1; rate_w = '1; burst_w = '1; win_w = '1;
        end
        2: begin
          en_w    = {15'($urandom), 1'b0};
          rate_w  = 16'($urandom_range(1, 50));
          burst_w = 16'($urandom_range(1, 30));
          win_w   = 16'($urandom_range(1, 4));
        end
        6: begin
          en_w = 16'd1; rate_w = 16'($urandom); burst_w = 16'($urandom);
          win_w = 16'($urandom);
        end
        default: begin
          en_w    = {15'($urandom), 1'b1};
          rate_w  = 16'($urandom_range(1, 50));
          burst_w = 16'($urandom_range(1, 30));
          win_w   = 16'($urandom_range(1, 4));
        end
      endcase
      write_reg(CFG_LIMIT_ENABLE,  en_w);
      write_reg(CFG_REFILL_RATE,   rate_w);
      write_reg(CFG_BURST_LIMIT,   burst_w);
      write_reg(CFG_WINDOW_LENGTH, win_w);
      cfg_valid_i <= 1'b0;
      calm  = (p == 3);
      stamp = $urandom;
      for (int k = 0; k < 160; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 80)
          stamp += NOW_W'($urandom_range(0, 400));
        else if (pick < 90)
          stamp += NOW_W'($urandom_range(400, 6000));
        else if (pick < 95)
          stamp = $urandom;
        else
          stamp -= NOW_W'($urandom_range(1, 1000));
        send_request(stamp, $urandom_range(0, 9) == 0, 1'b0, '0);
      end
    end
    calm = 1'b0;

    s_axis_tvalid <= 1'b0;
    drain_results();
    // room for a stray late result to show up
    repeat (200) @(posedge clk_i);
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin
    #20000000;
    $display("simulation failed");
    $finish;
  end

endmodule
